@@ rtl/core/ctbc_pkg.sv @@
package ctbc_pkg;

   localparam int CH_W    = 8;
   localparam int RATIO_W = 6;
   localparam int PROD_W  = CH_W + RATIO_W;
   localparam int COUNT_W = 25;
   localparam int SUM_W   = 36;
   localparam int FRAC_W  = 4;
   localparam int Q_W     = 16;

   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_MAX  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RED_MIN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO     = 2'd3;

   localparam logic [CH_W-1:0]    BLUE_MAX_RST  = 8'd70;
   localparam logic [CH_W-1:0]    GREEN_MAX_RST = 8'd70;
   localparam logic [CH_W-1:0]    RED_MIN_RST   = 8'd80;
   localparam logic [RATIO_W-1:0] RATIO_RST     = 6'd10;

   typedef struct packed {
      logic [CH_W-1:0]    blue_max;
      logic [CH_W-1:0]    green_max;
      logic [CH_W-1:0]    red_min;
      logic [RATIO_W-1:0] ratio_quarters;
   } cfg_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [SUM_W-1:0]   row_sum;
      logic [SUM_W-1:0]   col_sum;
   } totals_type;

endpackage

@@ rtl/core/ctbc_accum.sv @@
module ctbc_accum import ctbc_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            pix_accept,
   input  logic [CH_W-1:0] blue,
   input  logic [CH_W-1:0] green,
   input  logic [CH_W-1:0] red,
   input  logic            end_of_line,
   input  logic            end_of_frame,
   output totals_type      frame_totals
);

   localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;

   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   totals_type    tot_ff, tot_in, tot_upd;

   logic [PROD_W-1:0] red4, prod_b, prod_g;
   logic              is_red;
   logic [SUM_W:0]    row_add, col_add;

   always_comb begin
      red4   = PROD_W'({red, 2'b00});
      prod_b = PROD_W'(cfg.ratio_quarters) * PROD_W'(blue);
      prod_g = PROD_W'(cfg.ratio_quarters) * PROD_W'(green);
      is_red = (blue < cfg.blue_max) && (green < cfg.green_max) && (red > cfg.red_min)
               && (red4 > prod_b) && (red4 > prod_g);
   end

   // Accumulators saturate at all ones instead of wrapping.
   always_comb begin
      row_add = {1'b0, tot_ff.row_sum} + (SUM_W+1)'(row_ff);
      col_add = {1'b0, tot_ff.col_sum} + (SUM_W+1)'(col_ff);
      tot_upd = tot_ff;
      if (is_red) begin
         if (tot_ff.count != '1) begin
            tot_upd.count = tot_ff.count + COUNT_W'(1);
         end
         tot_upd.row_sum = row_add[SUM_W] ? '1 : row_add[SUM_W-1:0];
         tot_upd.col_sum = col_add[SUM_W] ? '1 : col_add[SUM_W-1:0];
      end
   end

   assign frame_totals = tot_upd;

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      tot_in = tot_ff;
      if (pix_accept) begin
         if (end_of_frame) begin
            col_in = '0;
            row_in = '0;
            tot_in = '0;
         end else begin
            tot_in = tot_upd;
            if (end_of_line) begin
               col_in = '0;
               if (row_ff < RW'(MAX_HEIGHT - 1)) begin
                  row_in = row_ff + RW'(1);
               end
            end else if (col_ff < CW'(MAX_WIDTH - 1)) begin
               col_in = col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         tot_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         tot_ff <= tot_in;
      end
   end

endmodule

@@ rtl/core/ctbc_div.sv @@
module ctbc_div import ctbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [SUM_W-1:0]   sum,
   input  logic [COUNT_W-1:0] count,
   output logic               done,
   output logic [Q_W-1:0]     quotient
);

   localparam int DVD_W  = SUM_W + FRAC_W;
   localparam int STEP_W = $clog2(DVD_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [DVD_W-1:0]   dvd_ff, dvd_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic [Q_W-1:0]     quo_ff, quo_in;

   logic [COUNT_W:0]   trial, diff;
   logic               fits;

   // One restoring step per cycle: the remainder stays below the divisor, so
   // the trial value needs only one bit more than the divisor.
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_W-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DVD_W - 1);
         dvd_in  = {sum, {FRAC_W{1'b0}}};
         rem_in  = '0;
         div_in  = count;
         quo_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_W-2:0], 1'b0};
         rem_in = fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
         quo_in = {quo_ff[Q_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - STEP_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/core/color_threshold_blob_centroid.sv @@
// Red-blob centroid finder for a raster stream of BGR pixels. Each accepted pixel
// beat runs the color test and updates the pixel count and the row and column
// sums. The beat with tlast (end of frame) is counted first and then starts the
// frame-end work, during which req_tready is low: the row and column means are
// formed one after the other on a single shared restoring divider that resolves
// one of 40 quotient bits per cycle. The result beat then sits in an output
// register, and pixels of the next frame are accepted while it waits; the result
// of a further frame end waits for that register to drain. Centroids carry 4
// fractional bits and are truncated; with no red pixel found, count and
// centroids read zero.
module color_threshold_blob_centroid import ctbc_pkg::*; #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [23:0]          req_tdata,  // blue, green, red
   input  logic                 req_tlast,  // end_of_frame
   input  logic                 req_tuser,  // end_of_line
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,  // center_row_q4, center_col_q4, pixel_count
   output logic                 rsp_tuser,  // found
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CH_W-1:0]      csr_wdata
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_ROW_GO   = 3'd1;
   localparam logic [2:0] S_ROW_WAIT = 3'd2;
   localparam logic [2:0] S_COL_GO   = 3'd3;
   localparam logic [2:0] S_COL_WAIT = 3'd4;
   localparam logic [2:0] S_EMIT     = 3'd5;

   logic [2:0]     state_ff, state_in;
   cfg_type        cfg_ff, cfg_in;
   totals_type     snap_ff, snap_in, frame_totals;
   logic [Q_W-1:0] row_q_ff, row_q_in;
   logic [Q_W-1:0] col_q_ff, col_q_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [63:0]    rsp_data_ff, rsp_data_in;
   logic           rsp_found_ff, rsp_found_in;

   logic           pix_accept;
   logic           div_start, div_done;
   logic [SUM_W-1:0] div_sum;
   logic [Q_W-1:0] div_quo;
   logic           found;

   assign req_tready = (state_ff == S_IDLE);
   assign pix_accept = req_tvalid && req_tready;

   ctbc_accum #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_HEIGHT(MAX_HEIGHT)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .pix_accept  (pix_accept),
      .blue        (req_tdata[7:0]),
      .green       (req_tdata[15:8]),
      .red         (req_tdata[23:16]),
      .end_of_line (req_tuser),
      .end_of_frame(req_tlast),
      .frame_totals(frame_totals)
   );

   assign div_start = (state_ff == S_ROW_GO) || (state_ff == S_COL_GO);
   assign div_sum   = (state_ff == S_COL_GO) ? snap_ff.col_sum : snap_ff.row_sum;

   ctbc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .sum     (div_sum),
      .count   (snap_ff.count),
      .done    (div_done),
      .quotient(div_quo)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_BLUE_MAX:  cfg_in.blue_max       = csr_wdata;
            CSR_GREEN_MAX: cfg_in.green_max      = csr_wdata;
            CSR_RED_MIN:   cfg_in.red_min        = csr_wdata;
            CSR_RATIO:     cfg_in.ratio_quarters = csr_wdata[RATIO_W-1:0];
            default:       cfg_in                = cfg_ff;
         endcase
      end
   end

   assign found = (snap_ff.count != '0);

   always_comb begin
      state_in     = state_ff;
      snap_in      = snap_ff;
      row_q_in     = row_q_ff;
      col_q_in     = col_q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pix_accept && req_tlast) begin
               snap_in  = frame_totals;
               state_in = S_ROW_GO;
            end
         end
         S_ROW_GO:   state_in = S_ROW_WAIT;
         S_ROW_WAIT: begin
            if (div_done) begin
               row_q_in = div_quo;
               state_in = S_COL_GO;
            end
         end
         S_COL_GO:   state_in = S_COL_WAIT;
         S_COL_WAIT: begin
            if (div_done) begin
               col_q_in = div_quo;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // The result beat is loaded only once the previous one has gone.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = found;
               rsp_data_in[15:0]  = found ? row_q_ff : '0;
               rsp_data_in[31:16] = found ? col_q_ff : '0;
               rsp_data_in[56:32] = snap_ff.count;
               rsp_data_in[63:57] = '0;
               state_in           = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{blue_max: BLUE_MAX_RST, green_max: GREEN_MAX_RST,
                           red_min: RED_MIN_RST, ratio_quarters: RATIO_RST};
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cfg_ff       <= cfg_in;
      end
      snap_ff      <= snap_in;
      row_q_ff     <= row_q_in;
      col_q_ff     <= col_q_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

endmodule

@@ sim/tb_color_threshold_blob_centroid.sv @@
module tb_color_threshold_blob_centroid;
   import ctbc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAME_MAX_W   = 4096;
   localparam int FRAME_MAX_H   = 4096;
   localparam int SETTLE_CYCLES = 100;   // wait after the frame-end divide before registers change
   localparam int IDLE_LIMIT    = 3000;
   localparam int RANDOM_ITEMS  = 200;   // least number of random pixel beats per register setting
   localparam int LONG_RUN      = 48;    // length of the long row and number of the one-pixel rows

   localparam int ROW_Q_LSB = 0;
   localparam int COL_Q_LSB = Q_W;
   localparam int COUNT_LSB = 2 * Q_W;

   typedef struct {
      logic               found;
      logic [Q_W-1:0]     row_q4;
      logic [Q_W-1:0]     col_q4;
      logic [COUNT_W-1:0] count;
   } centroid_beat_type;

   class centroid_tracker;
      cfg_type            cfg;
      int                 col_pos;
      int                 row_pos;
      logic [COUNT_W-1:0] red_count;
      logic [SUM_W-1:0]   row_sum;
      logic [SUM_W-1:0]   col_sum;
      centroid_beat_type  pending[$];
      int                 errors;
      int                 pixels;
      int                 frames;
      int                 red_frames;

      function new();
         cfg.blue_max       = BLUE_MAX_RST;
         cfg.green_max      = GREEN_MAX_RST;
         cfg.red_min        = RED_MIN_RST;
         cfg.ratio_quarters = RATIO_RST;
         clear_frame();
         errors     = 0;
         pixels     = 0;
         frames     = 0;
         red_frames = 0;
      endfunction

      function void clear_frame();
         col_pos   = 0;
         row_pos   = 0;
         red_count = '0;
         row_sum   = '0;
         col_sum   = '0;
      endfunction

      function void set_reg(logic [CSR_IDX_W-1:0] idx, logic [CH_W-1:0] value);
         case (idx)
            CSR_BLUE_MAX:  cfg.blue_max = value;
            CSR_GREEN_MAX: cfg.green_max = value;
            CSR_RED_MIN:   cfg.red_min = value;
            CSR_RATIO:     cfg.ratio_quarters = value[RATIO_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, int pos);
         logic [SUM_W:0] s;
         s = {1'b0, acc} + SUM_W'(pos);
         return s[SUM_W] ? '1 : s[SUM_W-1:0];
      endfunction

      function void note_pixel(logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r,
                               logic eol, logic eof);
         bit                hit;
         centroid_beat_type exp;
         longint            num;
         pixels++;
         hit = (b < cfg.blue_max) && (g < cfg.green_max) && (r > cfg.red_min) &&
               (4 * int'(r) > int'(cfg.ratio_quarters) * int'(b)) &&
               (4 * int'(r) > int'(cfg.ratio_quarters) * int'(g));
         if (hit) begin
            if (red_count != '1) red_count = red_count + 1'b1;
            row_sum = sat_sum(row_sum, row_pos);
            col_sum = sat_sum(col_sum, col_pos);
         end
         if (eof) begin
            exp.found  = (red_count != 0);
            exp.row_q4 = '0;
            exp.col_q4 = '0;
            exp.count  = red_count;
            if (exp.found) begin
               num        = longint'(row_sum) * 16;
               exp.row_q4 = Q_W'(num / longint'(red_count));
               num        = longint'(col_sum) * 16;
               exp.col_q4 = Q_W'(num / longint'(red_count));
               red_frames++;
            end
            pending.push_back(exp);
            frames++;
            clear_frame();
            return;
         end
         if (eol) begin
            col_pos = 0;
            if (row_pos < FRAME_MAX_H - 1) row_pos++;
         end else if (col_pos < FRAME_MAX_W - 1) begin
            col_pos++;
         end
      endfunction

      function void check_result(logic found, logic [Q_W-1:0] row_q4, logic [Q_W-1:0] col_q4,
                                 logic [COUNT_W-1:0] count);
         centroid_beat_type exp;
         if (pending.size() == 0) begin
            $error("result beat with no frame end outstanding");
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (found !== exp.found) begin
            $error("found: expected %0d, got %0d", exp.found, found);
            errors++;
         end
         if (row_q4 !== exp.row_q4) begin
            $error("center_row_q4: expected %0d, got %0d", exp.row_q4, row_q4);
            errors++;
         end
         if (col_q4 !== exp.col_q4) begin
            $error("center_col_q4: expected %0d, got %0d", exp.col_q4, col_q4);
            errors++;
         end
         if (count !== exp.count) begin
            $error("pixel_count: expected %0d, got %0d", exp.count, count);
            errors++;
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;  // blue, green, red
   logic                 req_tlast = 1'b0;  // end_of_frame
   logic                 req_tuser = 1'b0;  // end_of_line
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;  // center_row_q4, center_col_q4, pixel_count
   logic                 rsp_tuser;  // found
   logic                 csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CH_W-1:0]      csr_wdata = '0;

   centroid_tracker tracker = new();
   int              calm_left = 0;
   int              settings = 0;
   int              rsp_hold = 0;
   int              idle_cycles = 0;

   color_threshold_blob_centroid #(
      .MAX_WIDTH (FRAME_MAX_W),
      .MAX_HEIGHT(FRAME_MAX_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The receiver alternates between ready stretches, short stalls and a few long ones.
   always @(posedge clock) begin
      int pick;
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            rsp_tready <= 1'b1;
            rsp_hold   <= $urandom_range(0, 20);
         end else if (pick < 90) begin
            rsp_tready <= 1'b0;
            rsp_hold   <= $urandom_range(0, 3);
         end else begin
            rsp_tready <= 1'b0;
            rsp_hold   <= $urandom_range(10, 60);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tuser, rsp_tdata[ROW_Q_LSB +: Q_W],
                              rsp_tdata[COL_Q_LSB +: Q_W], rsp_tdata[COUNT_LSB +: COUNT_W]);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no beat moved for %0d cycles", IDLE_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   function automatic int pick_gap();
      int pick;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         calm_left = $urandom_range(20, 60);
         return 0;
      end
      if (pick < 65) return 0;
      if (pick < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_pixel(input logic [CH_W-1:0] b, input logic [CH_W-1:0] g,
                             input logic [CH_W-1:0] r, input logic eol, input logic eof);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {r, g, b};
      req_tlast  <= eof;
      req_tuser  <= eol;
      do @(posedge clock); while (!req_tready);
      tracker.note_pixel(b, g, r, eol, eof);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until every frame end has produced its result beat; with settle set it
   // also leaves time for the block to go quiet before registers change.
   task automatic wait_results(input bit settle);
      if (req_tvalid) req_tvalid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CH_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      tracker.set_reg(idx, value);
   endtask

   // Red-leaning pixels are drawn inside the current limits, boundary values included.
   task automatic pick_pixel(input int red_pct, output logic [CH_W-1:0] b,
                             output logic [CH_W-1:0] g, output logic [CH_W-1:0] r);
      if ($urandom_range(0, 99) < red_pct) begin
         b = CH_W'($urandom_range(0, tracker.cfg.blue_max));
         g = CH_W'($urandom_range(0, tracker.cfg.green_max));
         r = CH_W'($urandom_range(tracker.cfg.red_min, 255));
         if ($urandom_range(0, 1)) b = b >> 3;
         if ($urandom_range(0, 1)) g = g >> 3;
      end else begin
         b = CH_W'($urandom_range(0, 255));
         g = CH_W'($urandom_range(0, 255));
         r = CH_W'($urandom_range(0, 255));
      end
   endtask

   task automatic send_frame(input int width, input int height, input int red_pct);
      logic [CH_W-1:0] b;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] r;
      logic            eol;
      logic            eof;
      for (int row = 0; row < height; row++) begin
         for (int col = 0; col < width; col++) begin
            eol = (col == width - 1);
            eof = (row == height - 1) && eol;
            // Now and then a row comes out ragged or the frame stops early.
            if (!eof && $urandom_range(0, 99) < 3) eol = !eol;
            if (!eof && $urandom_range(0, 199) == 0) eof = 1'b1;
            pick_pixel(red_pct, b, g, r);
            send_pixel(b, g, r, eol, eof);
            if (eof) return;
         end
      end
   endtask

   task automatic run_phase(input logic [CH_W-1:0] blue_max, input logic [CH_W-1:0] green_max,
                            input logic [CH_W-1:0] red_min, input logic [CH_W-1:0] ratio,
                            input bit long_frame);
      logic [CH_W-1:0] b;
      logic [CH_W-1:0] g;
      logic [CH_W-1:0] r;
      int              start;
      wait_results(1'b1);
      write_reg(CSR_BLUE_MAX, blue_max);
      write_reg(CSR_GREEN_MAX, green_max);
      write_reg(CSR_RED_MIN, red_min);
      write_reg(CSR_RATIO, ratio);
      csr_we <= 1'b0;
      settings++;
      if (long_frame) begin
         // One long row, then a run of rows of a single pixel each.
         for (int i = 0; i < LONG_RUN; i++) begin
            pick_pixel(90, b, g, r);
            send_pixel(b, g, r, i == LONG_RUN - 1, 1'b0);
         end
         for (int i = 0; i < LONG_RUN; i++) begin
            pick_pixel(90, b, g, r);
            send_pixel(b, g, r, 1'b1, i == LONG_RUN - 1);
         end
      end
      start = tracker.pixels;
      while (tracker.pixels - start < RANDOM_ITEMS) begin
         if ($urandom_range(0, 99) < 6) wait_results(1'b0);
         if ($urandom_range(0, 9) == 0)
            send_frame($urandom_range(1, 40), $urandom_range(1, 3), 40);
         else
            send_frame($urandom_range(1, 10), $urandom_range(1, 6), 40);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default limits: blue and green below 70, red above 80, ratio 2.5.
      send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b1, 1'b1);
      send_pixel(8'd69, 8'd69, 8'd255, 1'b0, 1'b0);
      send_pixel(8'd70, 8'd0, 8'd255, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd70, 8'd255, 1'b1, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd80, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd81, 1'b0, 1'b0);
      send_pixel(8'd40, 8'd0, 8'd100, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd40, 8'd101, 1'b1, 1'b0);
      send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0);
      send_pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b1);

      run_phase(8'd255, 8'd255, 8'd0, 8'd0, 1'b1);
      run_phase(8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
      run_phase(8'd255, 8'd255, 8'd255, 8'd63, 1'b0);
      run_phase(8'd128, 8'd128, 8'd128, 8'd255, 1'b0);
      run_phase(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)), 1'b0);
      run_phase(CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)),
                CH_W'($urandom_range(0, 255)), CH_W'($urandom_range(0, 255)), 1'b0);
      run_phase(BLUE_MAX_RST, GREEN_MAX_RST, RED_MIN_RST, CH_W'(RATIO_RST), 1'b0);
      wait_results(1'b1);

      $display("Sent %0d pixel beats in %0d frames, %0d of them with red found,",
               tracker.pixels, tracker.frames, tracker.red_frames);
      $display("under %0d threshold settings with ragged rows and early frame ends.",
               settings);
      if (tracker.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/ctbc_pkg.sv
rtl/core/ctbc_accum.sv
rtl/core/ctbc_div.sv
rtl/core/color_threshold_blob_centroid.sv
sim/tb_color_threshold_blob_centroid.sv
